/* hdl/bank_conflict_degree_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for bank_conflict_degree_top
// Shared property forms: same-cycle and next-cycle implication on clk.
// ----------------------------------------------------------------------------
`ifndef BANK_CONFLICT_DEGREE_TOP_ASSERT_SVH
`define BANK_CONFLICT_DEGREE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/bcd_pkg.sv */
// ----------------------------------------------------------------------------
// bcd_pkg
// Constants and types shared by the bank conflict degree block.
// ----------------------------------------------------------------------------
package bcd_pkg;

	localparam int NUM_BANKS       = 32;
	localparam int MAX_ADDRESSES   = 32;
	localparam int ADDRESS_BITS    = 32;

	localparam int ADDR_FIELD_BITS = 32;  // width of the byte_address field
	localparam int WAYS_BITS       = 6;   // width of the bank_ways field
	localparam int WAYS_MAX        = 63;
	localparam int WORD_SHIFT      = 2;   // 4-byte words

	localparam int WORD_BITS = ADDRESS_BITS - WORD_SHIFT;
	localparam int BANK_BITS = $clog2(NUM_BANKS);
	localparam int CNT_BITS  = $clog2(MAX_ADDRESSES + 1);

	// one address travelling down the cell chain
	typedef struct packed {
		logic                 valid;
		logic                 last;
		logic                 hit;     // word matched or was stored on the way
		logic                 stored;  // word was stored by some cell
		logic [WORD_BITS-1:0] word;
	} token_t;

endpackage

/* hdl/bcd_in_if.sv */
// ----------------------------------------------------------------------------
// bcd_in_if
// Address channel: one byte address per transaction, last marks phase end.
// ----------------------------------------------------------------------------
interface bcd_in_if;
	import bcd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [ADDR_FIELD_BITS-1:0] byte_address;
	logic                       last_address;

	modport source (output valid, output byte_address, output last_address, input ready);
	modport sink   (input valid, input byte_address, input last_address, output ready);

endinterface

/* hdl/bcd_out_if.sv */
// ----------------------------------------------------------------------------
// bcd_out_if
// Result channel: conflict degree and overflow flag of one phase.
// ----------------------------------------------------------------------------
interface bcd_out_if;
	import bcd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [WAYS_BITS-1:0] bank_ways;
	logic                 overflowed;

	modport source (output valid, output bank_ways, output overflowed, input ready);
	modport sink   (input valid, input bank_ways, input overflowed, output ready);

endinterface

/* hdl/bank_conflict_degree_top.sv */
// ----------------------------------------------------------------------------
// bank_conflict_degree_top
// Bank conflict degree of one shared-memory access phase.
// ----------------------------------------------------------------------------
// Accepts one byte address per cycle. Each address turns into a word number
// and walks a chain of MAX_ADDRESSES store cells, one cell per cycle; a cell
// either matches the word or, if empty, keeps it. Past the chain a tally
// counts new words per bank and tracks the largest count. The result of a
// phase leaves through the result register: the edge that accepts its last
// address loads the first cell register, each further cell register follows
// in turn and the result register comes last. Addresses keep flowing at one
// per cycle; input is held only while a phase end reaches the tally and the
// previous result has not yet been taken.
// ----------------------------------------------------------------------------
module bank_conflict_degree_top (
	input  logic      clk,
	input  logic      arst_n,
	bcd_in_if.sink    addr_stream,
	bcd_out_if.source result_stream
);
	import bcd_pkg::*;

	token_t chain [MAX_ADDRESSES+1];
	logic   advance;

	always_comb begin
		chain[0].valid  = addr_stream.valid;
		chain[0].last   = addr_stream.last_address;
		chain[0].hit    = 1'b0;
		chain[0].stored = 1'b0;
		chain[0].word   = addr_stream.byte_address[ADDRESS_BITS-1:WORD_SHIFT];
	end

	assign addr_stream.ready = advance;

	for (genvar i = 0; i < MAX_ADDRESSES; i++) begin : g_cell
		bcd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok     (chain[i]),
			.tok_q   (chain[i+1])
		);
	end

	bcd_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok     (chain[MAX_ADDRESSES]),
		.advance (advance),
		.result  (result_stream)
	);

endmodule

/* hdl/bcd_cell.sv */
// ----------------------------------------------------------------------------
// bcd_cell
// One slot of the distinct-word store; compares, claims if empty, passes on.
// ----------------------------------------------------------------------------
module bcd_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  bcd_pkg::token_t tok,
	output bcd_pkg::token_t tok_q
);
	import bcd_pkg::*;

	logic                 slot_valid_q;
	logic [WORD_BITS-1:0] slot_word_q;
	logic                 match;
	logic                 claim;
	token_t               tok_next;

	assign match = tok.valid && !tok.hit && slot_valid_q && (slot_word_q == tok.word);
	// slots fill in order, so the first empty one a new word meets is the next free
	assign claim = tok.valid && !tok.hit && !slot_valid_q;

	always_comb begin
		tok_next        = tok;
		tok_next.hit    = tok.hit | match | claim;
		tok_next.stored = tok.stored | claim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= 1'b0;
			tok_q        <= '0;
		end else if (advance) begin
			// the last transaction of a phase empties each slot as it passes
			if (tok.valid && tok.last) begin
				slot_valid_q <= 1'b0;
			end else if (claim) begin
				slot_valid_q <= 1'b1;
			end
			tok_q <= tok_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (claim) begin
				slot_word_q <= tok.word;
			end
		end
	end

endmodule

/* hdl/bcd_tally.sv */
// ----------------------------------------------------------------------------
// bcd_tally
// End of the chain: per-bank word counts, running maximum, result register.
// ----------------------------------------------------------------------------
module bcd_tally (
	input  logic            clk,
	input  logic            arst_n,
	input  bcd_pkg::token_t tok,
	output logic            advance,
	bcd_out_if.source       result
);
	import bcd_pkg::*;

	localparam int CMP_BITS = (CNT_BITS > WAYS_BITS) ? CNT_BITS : WAYS_BITS;

	logic [CNT_BITS-1:0]  cnt_q [NUM_BANKS];
	logic [CNT_BITS-1:0]  max_q;
	logic                 ovf_q;
	logic                 out_valid_q;
	logic [WAYS_BITS-1:0] ways_q;
	logic                 ovf_out_q;

	logic [BANK_BITS-1:0] bank;
	logic [CNT_BITS-1:0]  inc;
	logic [CNT_BITS-1:0]  max_next;
	logic [CMP_BITS-1:0]  max_ext;
	logic [WAYS_BITS-1:0] ways_sat;
	logic                 ovf_next;
	logic                 finish;

	assign bank = BANK_BITS'(tok.word % NUM_BANKS);
	assign inc  = cnt_q[bank] + 1'b1;

	always_comb begin
		max_next = max_q;
		if (tok.valid && tok.stored && (inc > max_q)) begin
			max_next = inc;
		end
		max_ext  = CMP_BITS'(max_next);
		ways_sat = (max_ext > CMP_BITS'(WAYS_MAX)) ? WAYS_BITS'(WAYS_MAX)
		                                           : WAYS_BITS'(max_ext);
	end

	// a word reaching the end unclaimed found the store full
	assign ovf_next = ovf_q | (tok.valid && !tok.hit);
	assign finish   = tok.valid && tok.last;

	// hold the chain only when a phase end meets an untaken result
	assign advance = !(finish && out_valid_q && !result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BANKS; b++) begin
				cnt_q[b] <= '0;
			end
			max_q       <= CNT_BITS'(1);
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && tok.valid) begin
				if (tok.last) begin
					for (int b = 0; b < NUM_BANKS; b++) begin
						cnt_q[b] <= '0;
					end
					max_q <= CNT_BITS'(1);
					ovf_q <= 1'b0;
				end else begin
					if (tok.stored) begin
						cnt_q[bank] <= inc;
					end
					max_q <= max_next;
					ovf_q <= ovf_next;
				end
			end
			if (advance && finish) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && finish) begin
			ways_q    <= ways_sat;
			ovf_out_q <= ovf_next;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.bank_ways  = ways_q;
	assign result.overflowed = ovf_out_q;

endmodule

/* hdl/bcd_checker.sv */
// ----------------------------------------------------------------------------
// bcd_checker
// Port-level checks on the bank conflict degree block, bound to the top.
// ----------------------------------------------------------------------------
`include "bank_conflict_degree_top_assert.svh"

module bcd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          addr_valid,
	input logic                          addr_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [bcd_pkg::WAYS_BITS-1:0] bank_ways,
	input logic                          overflowed
);
	import bcd_pkg::*;

	logic res_stall;
	assign res_stall = res_valid && !res_ready;

	// a stalled result stays offered
	`BCD_ASSERT_NEXT(a_res_hold, res_stall, res_valid, "result dropped while stalled")
	// and keeps its payload
	`BCD_ASSERT_NEXT(a_res_stable, res_stall, $stable({bank_ways, overflowed}), "payload changed")
	// a phase always has at least one way
	`BCD_ASSERT_NOW(a_ways_nonzero, res_valid, bank_ways != '0, "bank_ways is zero")
	// input backpressure only comes from an occupied, untaken result
	`BCD_ASSERT_NOW(a_stall_cause, !addr_ready, res_stall, "input held without result backpressure")
	// a stalled address stays offered
	`BCD_ASSERT_NEXT(a_addr_hold, addr_valid && !addr_ready, addr_valid, "address withdrawn")

endmodule

bind bank_conflict_degree_top bcd_checker u_bcd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.addr_valid (addr_stream.valid),
	.addr_ready (addr_stream.ready),
	.res_valid  (result_stream.valid),
	.res_ready  (result_stream.ready),
	.bank_ways  (result_stream.bank_ways),
	.overflowed (result_stream.overflowed)
);

/* tb/sv/bank_conflict_degree_top_tb.sv */
// ----------------------------------------------------------------------------
// bank_conflict_degree_top_tb
// Self-checking bench for the bank conflict degree block.
// ----------------------------------------------------------------------------
// Phases of byte addresses go in over the address channel. A behavioural
// tally of distinct words per bank predicts each phase result, and every
// result transaction is checked against the oldest prediction. The sender
// works in bursts and the receiver stalls on changing patterns, with one long
// hold-off so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module bank_conflict_degree_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bcd_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 2 * (MAX_ADDRESSES + 1);
	localparam int RANDOM_ITEMS    = 920;

	typedef struct packed {
		logic [WAYS_BITS-1:0] bank_ways;
		logic                 overflowed;
	} phase_result_t;

	typedef enum int unsigned {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_pattern_t;
	typedef enum int unsigned {PH_CLUSTERED, PH_OVERFLOW, PH_SCATTERED, PH_SHORT} phase_kind_t;

	logic clk;
	logic arst_n;

	bcd_in_if  addr_if ();
	bcd_out_if res_if ();

	bank_conflict_degree_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.addr_stream  (addr_if),
		.result_stream(res_if)
	);

	// behavioural copy of the phase state
	logic [WORD_BITS-1:0] phase_words [MAX_ADDRESSES];
	int unsigned          phase_word_count;
	int unsigned          words_per_bank [NUM_BANKS];
	logic                 phase_dropped;

	phase_result_t expected_phase_results [$];

	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned burst_left;
	bit          sender_gaps_on;
	bit          hold_off_request;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic void clear_phase_tally();
		foreach (phase_words[i]) phase_words[i] = '0;
		foreach (words_per_bank[b]) words_per_bank[b] = 0;
		phase_word_count = 0;
		phase_dropped    = 1'b0;
	endfunction

	function automatic void account_address(input logic [ADDR_FIELD_BITS-1:0] addr,
	                                        input logic last);
		logic [WORD_BITS-1:0] word;
		int unsigned          bank;
		int unsigned          ways;
		bit                   known;
		phase_result_t        res;
		word  = WORD_BITS'(addr[ADDRESS_BITS-1:0] >> WORD_SHIFT);
		bank  = word % NUM_BANKS;
		known = 1'b0;
		for (int i = 0; i < phase_word_count; i++)
			if (phase_words[i] == word)
				known = 1'b1;
		if (!known) begin
			if (phase_word_count < MAX_ADDRESSES) begin
				phase_words[phase_word_count] = word;
				phase_word_count++;
				words_per_bank[bank]++;
			end else begin
				phase_dropped = 1'b1;
			end
		end
		if (last) begin
			ways = 1;
			foreach (words_per_bank[b])
				if (words_per_bank[b] > ways)
					ways = words_per_bank[b];
			if (ways > WAYS_MAX)
				ways = WAYS_MAX;
			res.bank_ways  = WAYS_BITS'(ways);
			res.overflowed = phase_dropped;
			expected_phase_results.push_back(res);
			clear_phase_tally();
		end
	endfunction

	// both channels sampled at the rising edge
	always @(posedge clk) begin
		phase_result_t want;
		if (arst_n) begin
			if (addr_if.valid && addr_if.ready)
				account_address(addr_if.byte_address, addr_if.last_address);
			if (res_if.valid && res_if.ready) begin
				if (expected_phase_results.size() == 0) begin
					$display("%0t: result transaction with none pending: ways %0d overflowed %0b",
					         $time, res_if.bank_ways, res_if.overflowed);
					fail_count++;
				end else begin
					want = expected_phase_results.pop_front();
					if (res_if.bank_ways !== want.bank_ways) begin
						$display("%0t: bank_ways expected %0d actual %0d",
						         $time, want.bank_ways, res_if.bank_ways);
						fail_count++;
					end
					if (res_if.overflowed !== want.overflowed) begin
						$display("%0t: overflowed expected %0b actual %0b",
						         $time, want.overflowed, res_if.overflowed);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time,
			         expected_phase_results.size());
			$display("status: fail");
			$finish;
		end
	end

	// receiver: changing stall patterns, plus one long hold-off on request
	initial begin
		rx_pattern_t pattern;
		int unsigned pattern_left;
		int unsigned on_len;
		int unsigned off_len;
		int unsigned pos;
		res_if.ready = 1'b0;
		pattern      = RX_ALWAYS;
		pattern_left = 0;
		on_len       = 1;
		off_len      = 1;
		pos          = 0;
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_off_request = 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern      = rx_pattern_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(50, 250);
					on_len       = $urandom_range(1, 6);
					off_len      = $urandom_range(1, 8);
					pos          = 0;
				end
				pattern_left--;
				case (pattern)
					RX_ALWAYS:   res_if.ready <= 1'b1;
					RX_HALF:     res_if.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   res_if.ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: begin
						res_if.ready <= ((pos % (on_len + off_len)) < on_len);
						pos++;
					end
				endcase
			end
		end
	end

	// one address transaction; valid stays high across a burst
	task automatic send_address(input logic [ADDR_FIELD_BITS-1:0] addr, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (sender_gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
			if (gap != 0) begin
				@(negedge clk);
				addr_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		addr_if.valid        <= 1'b1;
		addr_if.byte_address <= addr;
		addr_if.last_address <= last;
		do @(posedge clk); while (!addr_if.ready);
	endtask

	task automatic test_directed_phases();
		// single-address phases at the field extremes
		send_address('0, 1'b1);
		send_address('1, 1'b1);
		// repeated word: four byte offsets of one word
		send_address(32'h0000_0100, 1'b0);
		send_address(32'h0000_0101, 1'b0);
		send_address(32'h0000_0102, 1'b0);
		send_address(32'h0000_0103, 1'b1);
		// three distinct words in bank 0
		send_address(32'h0000_0000, 1'b0);
		send_address(32'h0000_0080, 1'b0);
		send_address(32'h0000_0100, 1'b1);
		// three distinct words in bank 31, top bits set and clear
		send_address(32'hFFFF_FFFC, 1'b0);
		send_address(32'h7FFF_FFFC, 1'b0);
		send_address(32'h0000_007C, 1'b1);
		// same word twice around a word in another bank
		send_address(32'hA5A5_A5A4, 1'b0);
		send_address(32'h5A5A_5A58, 1'b0);
		send_address(32'hA5A5_A5A7, 1'b1);
	endtask

	task automatic test_store_full();
		logic [24:0] row_base;
		logic [4:0]  target_bank;
		row_base    = 25'($urandom);
		target_bank = 5'($urandom);
		// full store in one bank
		for (int i = 0; i < MAX_ADDRESSES; i++)
			send_address({row_base + 25'(i), target_bank, 2'($urandom)},
			             i == MAX_ADDRESSES - 1);
		// one distinct word beyond capacity
		for (int i = 0; i <= MAX_ADDRESSES; i++)
			send_address({row_base + 25'(i), target_bank, 2'($urandom)}, i == MAX_ADDRESSES);
		// full store, then a repeat which must not overflow
		for (int i = 0; i < MAX_ADDRESSES; i++)
			send_address({row_base + 25'(i), target_bank, 2'($urandom)}, 1'b0);
		send_address({row_base, target_bank, 2'($urandom)}, 1'b1);
		// one word per bank, the extra word dropped
		for (int i = 0; i <= MAX_ADDRESSES; i++)
			send_address({row_base + 25'(i / NUM_BANKS), 5'(i), 2'($urandom)},
			             i == MAX_ADDRESSES);
	endtask

	task automatic test_random_phases();
		int unsigned                sent;
		int unsigned                len;
		int unsigned                n_rows;
		int unsigned                n_banks;
		phase_kind_t                kind;
		logic [24:0]                row_base;
		logic [4:0]                 bank_base;
		logic [ADDR_FIELD_BITS-1:0] addr;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9)) inside
				[0:4]:   kind = PH_CLUSTERED;
				[5:6]:   kind = PH_OVERFLOW;
				[7:8]:   kind = PH_SCATTERED;
				default: kind = PH_SHORT;
			endcase
			sender_gaps_on = ($urandom_range(0, 3) != 0);
			row_base       = 25'($urandom);
			bank_base      = 5'($urandom);
			n_rows         = $urandom_range(1, 40);
			n_banks        = $urandom_range(1, 4);
			case (kind)
				PH_CLUSTERED: len = $urandom_range(1, 32);
				PH_OVERFLOW: begin
					len     = $urandom_range(33, 40);
					n_rows  = $urandom_range(16, 64);
					n_banks = $urandom_range(2, 8);
				end
				PH_SCATTERED: len = $urandom_range(1, 36);
				default:      len = $urandom_range(1, 2);
			endcase
			for (int i = 0; i < len; i++) begin
				if (kind == PH_CLUSTERED || kind == PH_OVERFLOW)
					addr = {row_base + 25'($urandom_range(0, n_rows - 1)),
					        bank_base + 5'($urandom_range(0, n_banks - 1)), 2'($urandom)};
				else
					addr = $urandom;
				send_address(addr, i == len - 1);
			end
			sent += len;
		end
		sender_gaps_on = 1'b1;
	endtask

	// short phases back to back while the receiver holds off
	task automatic test_output_backpressure();
		int unsigned len;
		hold_off_request = 1'b1;
		sender_gaps_on   = 1'b0;
		for (int p = 0; p < 40; p++) begin
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++)
				send_address($urandom, i == len - 1);
		end
		sender_gaps_on = 1'b1;
	endtask

	initial begin
		arst_n               = 1'b0;
		addr_if.valid        = 1'b0;
		addr_if.byte_address = '0;
		addr_if.last_address = 1'b0;
		fail_count           = 0;
		cycle_count          = 0;
		burst_left           = 0;
		sender_gaps_on       = 1'b1;
		hold_off_request     = 1'b0;
		clear_phase_tally();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_phases();
		test_store_full();
		test_random_phases();
		test_output_backpressure();

		@(negedge clk);
		addr_if.valid <= 1'b0;
		while (expected_phase_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_phase_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/bcd_pkg.sv
hdl/bcd_in_if.sv
hdl/bcd_out_if.sv
hdl/bcd_cell.sv
hdl/bcd_tally.sv
hdl/bank_conflict_degree_top.sv
hdl/bcd_checker.sv
tb/sv/bank_conflict_degree_top_tb.sv
